FILE: rtl/bpe_pkg.sv
// bpe_pkg: shared types and constants of the bitmap pixel expander
// register indexes, screen orientations, configuration and queued work words
// used by the modules under rtl other than bpe_fifo
package bpe_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PixPerByte = 8;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_BITMAP_WIDTH  = 3'd2,
    REG_BITMAP_HEIGHT = 3'd3,
    REG_MSB_FIRST     = 3'd4,
    REG_ORIENTATION   = 3'd5,
    REG_DRAW_COLOR    = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ORIENT_PORTRAIT     = 2'd0,
    ORIENT_LANDSCAPE_CW = 2'd1,
    ORIENT_LANDSCAPE_CCW = 2'd2,
    ORIENT_PORTRAIT_180 = 2'd3
  } orient_e;

  typedef struct packed {
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic [CoordW-1:0] bitmap_width;
    logic [CoordW-1:0] bitmap_height;
    logic              msb_first;
    orient_e           orientation;
    logic [ColorW-1:0] draw_color;
  } cfg_t;

  // one byte worth of pixels, mask bit b is column b from the left
  typedef struct packed {
    logic [PixPerByte-1:0] mask;
    logic [CoordW-1:0]     lx0;
    logic [CoordW-1:0]     ly;
  } work_t;

  localparam int unsigned WorkW = $bits(work_t);

endpackage

FILE: rtl/bpe_fifo.sv
// bpe_fifo: small register queue between the front and back sections
// generic width and depth, full and empty flags decoded from a registered count
// no package dependency
module bpe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/bpe_front.sv
// bpe_front: accepts bitmap bytes, tracks row and byte-in-row position
// and turns each byte into a pixel mask with its logical base point
// depends on bpe_pkg
module bpe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpe_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 start_req_i,
  input  logic                 q_ready_i,
  output logic                 q_push_o,
  output bpe_pkg::work_t       q_work_o
);
  import bpe_pkg::*;

  logic [15:0] row_q, row_d;
  logic [12:0] bir_q, bir_d;
  logic        done_q, done_d;

  logic [15:0] eff_row, row_inc, col_base;
  logic [12:0] eff_bir;
  logic        eff_done, active, accept, wrap;
  logic [13:0] bpr;
  logic [PixPerByte-1:0] in_width, pix, mask;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign eff_row  = start_req_i ? '0 : row_q;
  assign eff_bir  = start_req_i ? '0 : bir_q;
  assign eff_done = start_req_i ? 1'b0 : done_q;
  assign active   = !eff_done && (cfg_i.bitmap_width != '0) &&
                    (eff_row < cfg_i.bitmap_height);

  assign bpr      = 14'((17'(cfg_i.bitmap_width) + 17'd7) >> 3);
  assign wrap     = (14'(eff_bir) + 14'd1) >= bpr;
  assign row_inc  = eff_row + 16'd1;
  assign col_base = {eff_bir, 3'b000};

  always_comb begin
    for (int b = 0; b < PixPerByte; b++) begin
      in_width[b] = (17'(col_base) + 17'(b)) < 17'(cfg_i.bitmap_width);
      pix[b]      = cfg_i.msb_first ? data_byte_i[PixPerByte-1-b] : data_byte_i[b];
    end
  end

  assign mask = in_width & pix & {PixPerByte{active}};

  assign q_push_o       = accept && (mask != '0);
  assign q_work_o.mask  = mask;
  assign q_work_o.lx0   = cfg_i.origin_x + col_base;
  assign q_work_o.ly    = cfg_i.origin_y + eff_row;

  always_comb begin
    row_d  = row_q;
    bir_d  = bir_q;
    done_d = done_q;
    if (accept) begin
      row_d = eff_row;
      bir_d = eff_bir;
      if (!active) begin
        done_d = 1'b1;
      end else if (wrap) begin
        bir_d  = '0;
        row_d  = row_inc;
        done_d = (row_inc >= cfg_i.bitmap_height) || (row_inc == '0);
      end else begin
        bir_d  = eff_bir + 13'd1;
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      bir_q  <= '0;
      done_q <= 1'b1;
    end else begin
      row_q  <= row_d;
      bir_q  <= bir_d;
      done_q <= done_d;
    end
  end

endmodule

FILE: rtl/bpe_back.sv
// bpe_back: walks the set bits of the queued pixel mask, one pixel a cycle unless the output stalls,
// maps each point for the screen orientation and holds it in the output register
// depends on bpe_pkg
module bpe_back #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320,
  parameter int unsigned COL_OFFSET   = 0,
  parameter int unsigned ROW_OFFSET   = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpe_pkg::cfg_t              cfg_i,
  input  logic                       q_valid_i,
  input  bpe_pkg::work_t             q_work_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bpe_pkg::CoordW-1:0] panel_col_o,
  output logic [bpe_pkg::CoordW-1:0] panel_row_o,
  output logic [bpe_pkg::ColorW-1:0] pixel_color_o,
  output logic                       last_pixel_o
);
  import bpe_pkg::*;

  localparam logic [CoordW-1:0] ColOff  = CoordW'(COL_OFFSET);
  localparam logic [CoordW-1:0] RowOff  = CoordW'(ROW_OFFSET);
  localparam logic [CoordW-1:0] ColBase = CoordW'(PANEL_WIDTH - 1 + COL_OFFSET);
  localparam logic [CoordW-1:0] RowBase = CoordW'(PANEL_HEIGHT - 1 + ROW_OFFSET);

  logic [PixPerByte-1:0] sent_q, sent_d, cur, first, rest;
  logic [2:0]            idx;
  logic [CoordW-1:0]     lx, ly, col_d, row_d, col_q, row_q;
  logic [ColorW-1:0]     color_q;
  logic                  valid_q, valid_d, last_q, step;

  assign cur   = q_work_i.mask & ~sent_q;
  assign first = cur & (~cur + PixPerByte'(1));
  assign rest  = cur & ~first;

  always_comb begin
    idx = '0;
    for (int i = 0; i < PixPerByte; i++) begin
      if (first[i]) begin
        idx = idx | 3'(i);
      end
    end
  end

  assign lx = q_work_i.lx0 + CoordW'(idx);
  assign ly = q_work_i.ly;

  always_comb begin
    unique case (cfg_i.orientation)
      ORIENT_PORTRAIT: begin
        col_d = lx + ColOff;
        row_d = ly + RowOff;
      end
      ORIENT_LANDSCAPE_CW: begin
        col_d = ly + ColOff;
        row_d = RowBase - lx;
      end
      ORIENT_LANDSCAPE_CCW: begin
        col_d = ColBase - ly;
        row_d = lx + RowOff;
      end
      ORIENT_PORTRAIT_180: begin
        col_d = ColBase - lx;
        row_d = RowBase - ly;
      end
      default: begin
        col_d = lx;
        row_d = ly;
      end
    endcase
  end

  assign step    = q_valid_i && (!valid_q || out_ready_i);
  assign q_pop_o = step && (rest == '0);

  always_comb begin
    sent_d  = sent_q;
    valid_d = valid_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (step) begin
      valid_d = 1'b1;
      sent_d  = (rest == '0) ? '0 : (sent_q | first);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= '0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      col_q   <= col_d;
      row_q   <= row_d;
      color_q <= cfg_i.draw_color;
      last_q  <= (rest == '0);
    end
  end

  assign out_valid_o   = valid_q;
  assign panel_col_o   = col_q;
  assign panel_row_o   = row_q;
  assign pixel_color_o = color_q;
  assign last_pixel_o  = last_q;

endmodule

FILE: rtl/bitmap_pixel_expander_core.sv
// bitmap_pixel_expander_core: top level, configuration registers, front, queue, back
// path: an accepted byte's mask goes into the queue, and the back section registers
// its pixel words in the output register; throughput: one pixel word a cycle while the
// output is not stalled, one per drawn pixel (at most 8); a byte with none is not queued
// reset: position counters cleared with the bitmap marked done, registers to defaults,
// queue and output register empty; depends on bpe_pkg, bpe_front, bpe_fifo, bpe_back
module bitmap_pixel_expander_core #(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320,
  parameter int unsigned COL_OFFSET   = 0,
  parameter int unsigned ROW_OFFSET   = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpe_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bpe_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         start_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bpe_pkg::CoordW-1:0]   panel_col_o,
  output logic [bpe_pkg::CoordW-1:0]   panel_row_o,
  output logic [bpe_pkg::ColorW-1:0]   pixel_color_o,
  output logic                         last_pixel_o
);
  import bpe_pkg::*;

  cfg_t  cfg_q, cfg_d;
  work_t push_work, head_work;
  logic  q_push, q_ready, q_valid, q_pop;
  logic [WorkW-1:0] head_bits;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ORIGIN_X:      cfg_d.origin_x      = cfg_wdata_i;
        REG_ORIGIN_Y:      cfg_d.origin_y      = cfg_wdata_i;
        REG_BITMAP_WIDTH:  cfg_d.bitmap_width  = cfg_wdata_i;
        REG_BITMAP_HEIGHT: cfg_d.bitmap_height = cfg_wdata_i;
        REG_MSB_FIRST:     cfg_d.msb_first     = cfg_wdata_i[0];
        REG_ORIENTATION:   cfg_d.orientation   = orient_e'(cfg_wdata_i[1:0]);
        REG_DRAW_COLOR:    cfg_d.draw_color    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.bitmap_width  <= 16'd8;
      cfg_q.bitmap_height <= 16'd8;
      cfg_q.msb_first     <= 1'b1;
      cfg_q.orientation   <= ORIENT_PORTRAIT;
      cfg_q.draw_color    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_work_o    (push_work)
  );

  bpe_fifo #(
    .WIDTH (WorkW),
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_work),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (head_bits)
  );

  assign head_work = work_t'(head_bits);

  bpe_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .COL_OFFSET   (COL_OFFSET),
    .ROW_OFFSET   (ROW_OFFSET)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_work_i      (head_work),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .panel_col_o   (panel_col_o),
    .panel_row_o   (panel_row_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

FILE: rtl/bpe_checker.sv
// bpe_checker: port-level checks on the input and pixel word streams of the expander
// bound to bitmap_pixel_expander_core; depends on bpe_pkg
module bpe_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [bpe_pkg::CoordW-1:0]   panel_col_o,
  input logic [bpe_pkg::CoordW-1:0]   panel_row_o,
  input logic [bpe_pkg::ColorW-1:0]   pixel_color_o,
  input logic                         last_pixel_o
);

  // offered input word waits until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input word withdrawn before it was taken");

  // stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(panel_col_o) && $stable(panel_row_o) &&
      $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("output word changed while stalled");

  // a byte's pixels come without gaps until its last one
  a_byte_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_pixel_o |=> out_valid_o)
    else $error("gap inside the pixel words of one byte");

  // nothing leaves in the first cycle after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind bitmap_pixel_expander_core bpe_checker u_bpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .panel_col_o   (panel_col_o),
  .panel_row_o   (panel_row_o),
  .pixel_color_o (pixel_color_o),
  .last_pixel_o  (last_pixel_o)
);

FILE: tb/bpe_pixel_checker.sv
// bpe_pixel_checker: watches the configuration port and both word channels of the core,
// predicts the pixel words of every accepted bitmap byte and compares them in order
// depends on bpe_pkg; hands its mismatch count and outstanding pixel count to tb_top
module bpe_pixel_checker
  import bpe_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320,
  parameter int unsigned COL_OFFSET   = 0,
  parameter int unsigned ROW_OFFSET   = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_req_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [CoordW-1:0]   panel_col_i,
  input  logic [CoordW-1:0]   panel_row_i,
  input  logic [ColorW-1:0]   pixel_color_i,
  input  logic                last_pixel_i,
  output int                  fail_cnt_o,
  output int                  pending_cnt_o
);

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [ColorW-1:0] color;
    logic              last;
  } pixel_word_t;

  pixel_word_t pending_pixels[$];
  pixel_word_t got_word;
  pixel_word_t want_word;

  logic [15:0] origin_x_q;
  logic [15:0] origin_y_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic        msb_first_q;
  orient_e     orient_q;
  logic [15:0] color_q;

  logic [15:0] row_q;
  logic [12:0] byte_q;
  logic        done_q;

  function automatic void expand_byte(input logic [7:0] d, input logic s);
    int unsigned row_bytes;
    int unsigned col;
    int unsigned n;
    int          b;
    logic        hit;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [31:0] t;
    logic [15:0] c;
    logic [15:0] r;
    pixel_word_t words[8];
    row_bytes = (32'(width_q) + 32'd7) / 32'd8;
    if (s) begin
      row_q  = '0;
      byte_q = '0;
      done_q = 1'b0;
    end
    if (done_q) return;
    if (row_bytes == 0 || row_q >= height_q) begin
      done_q = 1'b1;
      return;
    end
    ly = origin_y_q + row_q;
    n  = 0;
    for (b = 0; b < 8; b++) begin
      col = 32'(byte_q) * 8 + 32'(b);
      if (col >= 32'(width_q)) break;
      hit = msb_first_q ? d[7-b] : d[b];
      if (hit) begin
        lx = origin_x_q + col[15:0];
        case (orient_q)
          ORIENT_LANDSCAPE_CW: begin
            c = ly;
            t = 32'(PANEL_HEIGHT) - 32'd1 - 32'(lx);
            r = t[15:0];
          end
          ORIENT_LANDSCAPE_CCW: begin
            t = 32'(PANEL_WIDTH) - 32'd1 - 32'(ly);
            c = t[15:0];
            r = lx;
          end
          ORIENT_PORTRAIT_180: begin
            t = 32'(PANEL_WIDTH) - 32'd1 - 32'(lx);
            c = t[15:0];
            t = 32'(PANEL_HEIGHT) - 32'd1 - 32'(ly);
            r = t[15:0];
          end
          default: begin
            c = lx;
            r = ly;
          end
        endcase
        words[n].col   = c + 16'(COL_OFFSET);
        words[n].row   = r + 16'(ROW_OFFSET);
        words[n].color = color_q;
        words[n].last  = 1'b0;
        n++;
      end
    end
    if (n > 0) words[n-1].last = 1'b1;
    for (b = 0; b < int'(n); b++) pending_pixels.push_back(words[b]);
    // step to the next byte of the row, or to the next row
    if (32'(byte_q) + 32'd1 >= row_bytes) begin
      byte_q = '0;
      row_q  = row_q + 16'd1;
      if (row_q >= height_q || row_q == 16'd0) done_q = 1'b1;
    end else begin
      byte_q = byte_q + 13'd1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    = '0;
      origin_y_q    = '0;
      width_q       = 16'd8;
      height_q      = 16'd8;
      msb_first_q   = 1'b1;
      orient_q      = ORIENT_PORTRAIT;
      color_q       = '0;
      row_q         = '0;
      byte_q        = '0;
      done_q        = 1'b1;
      pending_pixels.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_word.col   = panel_col_i;
        got_word.row   = panel_row_i;
        got_word.color = pixel_color_i;
        got_word.last  = last_pixel_i;
        if (pending_pixels.size() == 0) begin
          $display("%0t: pixel word with none expected: col %h row %h color %h last %b",
                   $time, panel_col_i, panel_row_i, pixel_color_i, last_pixel_i);
          fail_cnt_o++;
        end else begin
          want_word = pending_pixels.pop_front();
          if (got_word !== want_word) begin
            $display("%0t: pixel word mismatch: expected col %h row %h color %h last %b",
                     $time, want_word.col, want_word.row, want_word.color, want_word.last);
            $display("%0t:                       actual col %h row %h color %h last %b",
                     $time, got_word.col, got_word.row, got_word.color, got_word.last);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_ORIGIN_X:      origin_x_q  = cfg_wdata_i;
          REG_ORIGIN_Y:      origin_y_q  = cfg_wdata_i;
          REG_BITMAP_WIDTH:  width_q     = cfg_wdata_i;
          REG_BITMAP_HEIGHT: height_q    = cfg_wdata_i;
          REG_MSB_FIRST:     msb_first_q = cfg_wdata_i[0];
          REG_ORIENTATION:   orient_q    = orient_e'(cfg_wdata_i[1:0]);
          REG_DRAW_COLOR:    color_q     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expand_byte(data_byte_i, start_req_i);
      pending_cnt_o = pending_pixels.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// tb_top: clock, reset and stimulus for bitmap_pixel_expander_core with random idling
// on both channels; bpe_pixel_checker beside the core does the prediction and word checking
// depends on bpe_pkg, bitmap_pixel_expander_core and bpe_pixel_checker
module tb_top;
  import bpe_pkg::*;

  localparam int unsigned PanelW       = 240;
  localparam int unsigned PanelH       = 320;
  localparam int unsigned ColOff       = 0;
  localparam int unsigned RowOff       = 0;
  localparam int unsigned RandomItems  = 260;
  localparam int unsigned MaxBurst     = 40;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned IdleLimit    = 4000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          data_byte;
  logic                start_req;
  logic                out_valid;
  logic                out_ready;
  logic [CoordW-1:0]   panel_col;
  logic [CoordW-1:0]   panel_row;
  logic [ColorW-1:0]   pixel_color;
  logic                last_pixel;
  int                  fail_cnt;
  int                  pending_cnt;

  bit          quiet;
  bit          stall_req;
  bit          stall_seen;
  int unsigned idle_cycles;
  int unsigned bytes_sent;

  bitmap_pixel_expander_core #(
    .PANEL_WIDTH (PanelW),
    .PANEL_HEIGHT(PanelH),
    .COL_OFFSET  (ColOff),
    .ROW_OFFSET  (RowOff)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .start_req_i  (start_req),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .panel_col_o  (panel_col),
    .panel_row_o  (panel_row),
    .pixel_color_o(pixel_color),
    .last_pixel_o (last_pixel)
  );

  bpe_pixel_checker #(
    .PANEL_WIDTH (PanelW),
    .PANEL_HEIGHT(PanelH),
    .COL_OFFSET  (ColOff),
    .ROW_OFFSET  (RowOff)
  ) u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_byte_i  (data_byte),
    .start_req_i  (start_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .panel_col_i  (panel_col),
    .panel_row_i  (panel_row),
    .pixel_color_i(pixel_color),
    .last_pixel_i (last_pixel),
    .fail_cnt_o   (fail_cnt),
    .pending_cnt_o(pending_cnt)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, MaxBurst);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setup(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic msb, input orient_e o, input logic [15:0] color);
    logic [15:0] v;
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_BITMAP_WIDTH, w);
    write_reg(REG_BITMAP_HEIGHT, h);
    // upper bits of the narrow registers are don't-care
    v = 16'($urandom);
    v[0] = msb;
    write_reg(REG_MSB_FIRST, v);
    v = 16'($urandom);
    v[1:0] = o;
    write_reg(REG_ORIENTATION, v);
    write_reg(REG_DRAW_COLOR, color);
  endtask

  task automatic send_word(input logic [7:0] d, input logic s);
    int unsigned gap;
    in_valid  = 1'b1;
    data_byte = d;
    start_req = s;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait for every expected pixel, then let the core settle
  task automatic settle();
    in_valid = 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold;
    out_ready  = 1'b0;
    stall_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_seen) begin
        stall_seen = 1'b1;
        hold = LongHold;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        hold = 0;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned kind;
    int unsigned i;
    int unsigned r;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = REG_ORIGIN_X;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    data_byte   = '0;
    start_req   = 1'b0;
    quiet       = 1'b0;
    stall_req   = 1'b0;
    bytes_sent  = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values: nothing drawn before a start, then a full 8x8 bitmap and one extra byte
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h3C, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h55, 1'b0);
    settle();

    // padded rows, both bit orders, coordinates at the top of the range, x wrapping past it
    load_setup(16'd65530, 16'd5, 16'd13, 16'd2, 1'b0, ORIENT_LANDSCAPE_CW, 16'hFFFF);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h0F, 1'b0);
    send_word(8'hF0, 1'b0);
    settle();
    load_setup(16'd0, 16'hFFFF, 16'd16, 16'd1, 1'b1, ORIENT_LANDSCAPE_CCW, 16'h8001);
    send_word(8'hAA, 1'b1);
    send_word(8'h55, 1'b0);
    settle();
    load_setup(16'hFFFF, 16'd0, 16'd8, 16'hFFFF, 1'b0, ORIENT_PORTRAIT_180, 16'h07E0);
    send_word(8'h81, 1'b1);
    send_word(8'hFF, 1'b0);
    settle();

    // empty bitmaps
    write_reg(REG_BITMAP_WIDTH, 16'd0);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    settle();
    write_reg(REG_BITMAP_WIDTH, 16'd8);
    write_reg(REG_BITMAP_HEIGHT, 16'd0);
    send_word(8'hFF, 1'b1);
    settle();

    // shape changed in the middle of a bitmap
    load_setup(16'd10, 16'd20, 16'd24, 16'd4, 1'b1, ORIENT_PORTRAIT, 16'h1234);
    send_word(8'hFF, 1'b1);
    send_word(8'hC3, 1'b0);
    settle();
    write_reg(REG_BITMAP_WIDTH, 16'd8);
    send_word(8'hE7, 1'b0);
    send_word(8'h99, 1'b0);
    settle();
    write_reg(REG_BITMAP_HEIGHT, 16'd1);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    settle();

    phase      = 0;
    while (bytes_sent < RandomItems) begin
      phase++;
      r  = $urandom_range(0, 3);
      ox = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF - 16'($urandom_range(0, 7)) : 16'($urandom);
      r  = $urandom_range(0, 3);
      oy = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF - 16'($urandom_range(0, 7)) : 16'($urandom);
      r  = $urandom_range(0, 19);
      w  = (r == 0) ? 16'hFFFF : (r < 4) ? 16'($urandom_range(1, 8))
                                         : 16'($urandom_range(1, 24));
      h  = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(1, 5));
      r  = $urandom_range(0, 5);
      color = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
      if (phase == 3) begin
        w = 16'd24;
        h = 16'd5;
      end
      load_setup(ox, oy, w, h, 1'($urandom), orient_e'($urandom_range(0, 3)), color);
      quiet = (phase % 4 == 0);
      if (phase == 3) stall_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
          repeat ($urandom_range(1, 6)) send_word(rand_byte(), $urandom_range(0, 7) == 0);
        end else begin
          len = ((32'(w) + 7) / 8) * 32'(h);
          if (len > MaxBurst) len = MaxBurst;
          if (kind == 7) len = $urandom_range(1, len);
          for (i = 0; i < len; i++) send_word(rand_byte(), i == 0);
          if ($urandom_range(0, 3) == 0) send_word(rand_byte(), 1'b0);
        end
      end
      settle();
    end

    quiet = 1'b0;
    settle();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bpe_pkg.sv
rtl/bpe_fifo.sv
rtl/bpe_front.sv
rtl/bpe_back.sv
rtl/bitmap_pixel_expander_core.sv
rtl/bpe_checker.sv
tb/bpe_pixel_checker.sv
tb/tb_top.sv
